FILE: sv/secu_pkg.sv
package secu_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned AddrWidth = 12;

   // Upper ten bits of the address of each group of four registers.
   localparam logic [9:0] MachineGroup = 10'h0C3;
   localparam logic [9:0] SuperGroup   = 10'h043;
   localparam logic [9:0] HyperGroup   = 10'h183;

   localparam logic [1:0] PrivMachine = 2'd3;

   localparam logic ModeRead  = 1'b0;
   localparam logic ModeWrite = 1'b1;

   localparam int unsigned Se0Pos    = 63;
   localparam int unsigned EnvcfgPos = 62;
   localparam int unsigned SrmcfgPos = 55;

   localparam logic CfgIndexHypPresent = 1'b0;

   typedef struct packed {
      logic                 mode;
      logic [AddrWidth-1:0] csr_addr;
      logic [DataWidth-1:0] wdata;
      logic [1:0]           priv;
      logic                 virt;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] rdata;
      logic                 is_stateen;
      logic                 permitted;
      logic                 denial_virtual;
   } rsp_type;

endpackage

FILE: sv/secu_access.sv
module secu_access (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid,
   input  secu_pkg::req_type req,
   input  logic             hyp_present,
   output secu_pkg::rsp_type rsp
);
   import secu_pkg::*;

   // Machine bits are held as {SE0, ENVCFG, SRMCFG}, hypervisor bits as {SE0, ENVCFG}.
   logic [2:0] m_bits_ff, m_bits_in;
   logic [1:0] h_bits_ff, h_bits_in;

   logic       is_m, is_s, is_h, idx_zero, hv;
   logic [2:0] m_raw;
   logic [1:0] h_raw;
   logic       permitted;

   always_comb begin
      is_m     = req.csr_addr[AddrWidth-1:2] == MachineGroup;
      is_s     = req.csr_addr[AddrWidth-1:2] == SuperGroup;
      is_h     = req.csr_addr[AddrWidth-1:2] == HyperGroup;
      idx_zero = req.csr_addr[1:0] == 2'd0;
      hv       = hyp_present && req.virt;
      m_raw    = idx_zero ? m_bits_ff : 3'b000;
      h_raw    = idx_zero ? h_bits_ff : 2'b00;

      rsp = '0;
      rsp.is_stateen = is_m || is_s || is_h;
      if (is_m) begin
         rsp.rdata[Se0Pos]    = m_raw[2];
         rsp.rdata[EnvcfgPos] = m_raw[1];
         rsp.rdata[SrmcfgPos] = m_raw[0];
      end else if (is_h) begin
         rsp.rdata[Se0Pos]    = h_raw[1] && m_raw[2];
         rsp.rdata[EnvcfgPos] = h_raw[0] && m_raw[1];
      end

      if (req.priv == PrivMachine) begin
         permitted = 1'b1;
      end else if (!(is_s || is_h)) begin
         permitted = 1'b0;
      end else if (!m_raw[2]) begin
         permitted = 1'b0;
      end else begin
         permitted = !(hv && !h_raw[1]);
         rsp.denial_virtual = hv && !permitted;
      end
      rsp.permitted = permitted;

      m_bits_in = m_bits_ff;
      h_bits_in = h_bits_ff;
      if (valid && req.mode == ModeWrite && permitted && idx_zero) begin
         if (is_m) begin
            m_bits_in = {req.wdata[Se0Pos], req.wdata[EnvcfgPos], req.wdata[SrmcfgPos]};
         end else if (is_h) begin
            h_bits_in[1] = m_bits_ff[2] ? req.wdata[Se0Pos] : h_bits_ff[1];
            h_bits_in[0] = m_bits_ff[1] ? req.wdata[EnvcfgPos] : h_bits_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_bits_ff <= '0;
         h_bits_ff <= '0;
      end else begin
         m_bits_ff <= m_bits_in;
         h_bits_ff <= h_bits_in;
      end
   end

   a_h_se0_needs_m: assert property (@(posedge clock) disable iff (reset)
      (h_bits_ff[1] != $past(h_bits_ff[1])) |-> $past(m_bits_ff[2]))
      else $error("hstateen0 SE0 changed while mstateen0 SE0 was clear");

   a_h_env_needs_m: assert property (@(posedge clock) disable iff (reset)
      (h_bits_ff[0] != $past(h_bits_ff[0])) |-> $past(m_bits_ff[1]))
      else $error("hstateen0 ENVCFG changed while mstateen0 ENVCFG was clear");

   a_denied_no_change: assert property (@(posedge clock) disable iff (reset)
      (valid && !permitted) |=> ($stable(m_bits_ff) && $stable(h_bits_ff)))
      else $error("A denied request altered the enable state.");

endmodule

FILE: sv/state_enable_csr_unit.sv
// Channel    | Ports                                   | Direction
// request    | start, busy, req_data                   | in, busy out
// result     | rsp_valid, rsp_data                     | out
// register   | csr_psel .. csr_pready (APB, 32 bits)   | in/out
//
// One request is taken in every cycle; busy stays low.
// A request is registered on entry and its result is registered after the
// decode and masking stage, which also updates the enable bits in request order.
// Reset is synchronous; it clears the enable bits and sets hyp_present to one.
// The result is shown for one cycle and cannot be held off by the receiver.
module state_enable_csr_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  secu_pkg::req_type req_data,
   output logic              rsp_valid,
   output secu_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import secu_pkg::*;

   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    hyp_present_ff;
   logic    cfg_write;

   assign busy       = 1'b0;
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CfgIndexHypPresent);
   assign csr_prdata = (csr_paddr[2] == CfgIndexHypPresent) ? {31'd0, hyp_present_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hyp_present_ff <= 1'b1;
      end else if (cfg_write) begin
         hyp_present_ff <= csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   secu_access u_access (
      .clock       (clock),
      .reset       (reset),
      .valid       (req_valid_ff),
      .req         (req_ff),
      .hyp_present (hyp_present_ff),
      .rsp         (rsp_in)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_valid)
      else $error("A registered request produced no result.");

   a_permitted_not_virtual: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.permitted) |-> !rsp_data.denial_virtual)
      else $error("A permitted result also reports a virtual denial.");

   a_foreign_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_stateen) |->
         (rsp_data.rdata == '0 && !rsp_data.denial_virtual))
      else $error("A result for a foreign address carries data or a virtual denial.");

endmodule
